@@ hw/rtl/etc_pkg.sv @@
package etc_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int TYPE_COUNT    = 64;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam int TYPE_W   = 6;
	localparam int KEY_W    = 16;
	localparam int PAY_W    = 16;
	localparam int RATE_W   = 20;
	localparam int MASK_W   = 64;
	localparam int DATA_W   = 64;
	localparam int ADDR_W   = 5;
	localparam int REG_LSB  = 3;

	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);

	typedef enum logic [1:0] {
		REG_RATE   = 2'd0,
		REG_MASK   = 2'd1,
		REG_EXEMPT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [RATE_W-1:0] rate_ticks;
		logic [MASK_W-1:0] throttle_mask;
		logic [TYPE_W-1:0] exempt_type;
	} cfg_t;

	// one table entry as stored in the memory
	typedef struct packed {
		logic [TYPE_W-1:0] etype;
		logic [KEY_W-1:0]  key;
		logic [PAY_W-1:0]  payload;
		logic [RATE_W-1:0] remaining;
	} entry_t;

	typedef struct packed {
		logic [TYPE_W-1:0] etype;
		logic [KEY_W-1:0]  key;
		logic [PAY_W-1:0]  payload;
		logic              delayed;
		logic              full;
	} result_t;

	// zero rate counts as one tick
	function automatic logic [RATE_W-1:0] load_rate(input logic [RATE_W-1:0] rate);
		load_rate = (rate == '0) ? RATE_W'(1) : rate;
	endfunction

endpackage

@@ hw/rtl/etc_regs.sv @@
module etc_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [etc_pkg::ADDR_W-1:0]  paddr,
	input  logic [etc_pkg::DATA_W-1:0]  pwdata,
	output logic [etc_pkg::DATA_W-1:0]  prdata,
	output etc_pkg::cfg_t               cfg
);

	etc_pkg::cfg_t cfg_q;
	logic [1:0]    reg_sel;
	logic          wr_en;

	assign reg_sel = paddr[etc_pkg::ADDR_W-1:etc_pkg::REG_LSB];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_ticks    <= etc_pkg::RATE_RESET;
			cfg_q.throttle_mask <= '0;
			cfg_q.exempt_type   <= '0;
		end else if (wr_en) begin
			case (etc_pkg::reg_idx_t'(reg_sel))
				etc_pkg::REG_RATE:   cfg_q.rate_ticks <= pwdata[etc_pkg::RATE_W-1:0];
				etc_pkg::REG_MASK:   cfg_q.throttle_mask <= pwdata[etc_pkg::MASK_W-1:0];
				etc_pkg::REG_EXEMPT: cfg_q.exempt_type <= pwdata[etc_pkg::TYPE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (etc_pkg::reg_idx_t'(reg_sel))
			etc_pkg::REG_RATE:   prdata = etc_pkg::DATA_W'(cfg_q.rate_ticks);
			etc_pkg::REG_MASK:   prdata = etc_pkg::DATA_W'(cfg_q.throttle_mask);
			etc_pkg::REG_EXEMPT: prdata = etc_pkg::DATA_W'(cfg_q.exempt_type);
			default:             prdata = '0;
		endcase
	end

endmodule

@@ hw/rtl/event_throttle_coalescer_core.sv @@
// Event rate limiter with coalescing of throttled events per (type, key).
// Input channel (in_valid / in_stall): action 0 carries an event, action 1
// is one time tick. Output channel (out_valid / out_stall): emitted events,
// with last marking the final result of an input. An event of a throttled
// type that hits an existing table entry gives no result; a tick gives one
// result per expiring entry with a stored payload, possibly none.
// Configuration goes through the APB port: rate_ticks at 0x00,
// throttle_mask at 0x08, exempt_type at 0x10; pready is always high.
// The table lives in a 16-entry synchronous memory read one entry at a
// time; valid and pending bits are flip-flops.
// An unthrottled event goes through the hold stage into the output register,
// and the next item can be taken once it has left the hold stage.
// A throttled event or a tick walks the table: a free entry is skipped,
// a valid entry is read from memory, then modified and written back; an
// event that matches ends the walk, else ST_DONE finishes it. One item is
// worked on at a time; in_stall is high until it is done.
// A stalled output holds its result; the walk pauses when a second result
// is found before the first has left. Reset empties the table at once and
// loads the register reset values; no clearing pass is needed.
module event_throttle_coalescer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        action,
	input  logic [5:0]                  event_type,
	input  logic [15:0]                 key_tag,
	input  logic [15:0]                 payload_tag,
	input  logic                        stop_action,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [5:0]                  out_type,
	output logic [15:0]                 out_key,
	output logic [15:0]                 out_payload,
	output logic                        delayed,
	output logic                        table_full,
	output logic                        last,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [etc_pkg::ADDR_W-1:0]  paddr,
	input  logic [etc_pkg::DATA_W-1:0]  pwdata,
	output logic [etc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_EV,
		ST_DONE,
		ST_FLUSH
	} state_t;

	localparam logic [etc_pkg::IDX_W-1:0] LAST_IDX = etc_pkg::IDX_W'(etc_pkg::TABLE_ENTRIES - 1);

	etc_pkg::cfg_t    cfg;
	state_t           state_q;
	logic [etc_pkg::IDX_W-1:0]  idx_q;
	logic             tick_q;
	logic [5:0]       cur_type_q;
	logic [15:0]      cur_key_q;
	logic [15:0]      cur_pay_q;
	logic [etc_pkg::TABLE_ENTRIES-1:0] valid_q;
	logic [etc_pkg::TABLE_ENTRIES-1:0] pend_q;
	logic             hold_valid_q;
	etc_pkg::result_t hold_q;
	logic             out_valid_q;
	etc_pkg::result_t out_q;
	logic             out_last_q;

	etc_pkg::entry_t  mem [etc_pkg::TABLE_ENTRIES];
	etc_pkg::entry_t  rd_data_q;
	logic             mem_we;
	logic [etc_pkg::IDX_W-1:0]  mem_waddr;
	etc_pkg::entry_t  mem_wdata;

	logic             throttled;
	logic             out_free;
	logic             out_push;
	logic             match;
	logic             expired;
	logic             ev_block;
	logic             last_ent;
	logic             free_found;
	logic [etc_pkg::IDX_W-1:0]  free_idx;
	logic [etc_pkg::RATE_W-1:0] reload;

	etc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready   = 1'b1;
	assign in_stall = (state_q != ST_IDLE);

	assign out_valid   = out_valid_q;
	assign out_type    = out_q.etype;
	assign out_key     = out_q.key;
	assign out_payload = out_q.payload;
	assign delayed     = out_q.delayed;
	assign table_full  = out_q.full;
	assign last        = out_last_q;

	assign throttled = ({1'b0, event_type} < 7'(etc_pkg::TYPE_COUNT))
		&& cfg.throttle_mask[event_type]
		&& !(event_type == cfg.exempt_type && stop_action);

	assign out_free = !out_valid_q || !out_stall;
	assign reload   = etc_pkg::load_rate(cfg.rate_ticks);
	assign match    = (rd_data_q.etype == cur_type_q) && (rd_data_q.key == cur_key_q);
	assign expired  = (rd_data_q.remaining <= etc_pkg::RATE_W'(1));
	// a second delayed result waits until the first one has left the hold stage
	assign ev_block = (state_q == ST_EV) && tick_q && expired && pend_q[idx_q]
		&& hold_valid_q && !out_free;
	assign last_ent = (idx_q == LAST_IDX);
	// load the output register from the hold stage
	assign out_push = ((state_q == ST_FLUSH) && out_free)
		|| ((state_q == ST_EV) && tick_q && expired && pend_q[idx_q] && hold_valid_q
			&& out_free);

	// lowest free entry
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = etc_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = etc_pkg::IDX_W'(i);
			end
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = rd_data_q;
		case (state_q)
			ST_EV: begin
				if (!tick_q) begin
					if (match) begin
						mem_we            = 1'b1;
						mem_wdata.payload = cur_pay_q;
					end
				end else if (!expired) begin
					mem_we              = 1'b1;
					mem_wdata.remaining = rd_data_q.remaining - etc_pkg::RATE_W'(1);
				end else if (pend_q[idx_q] && !ev_block) begin
					mem_we              = 1'b1;
					mem_wdata.payload   = '0;
					mem_wdata.remaining = reload;
				end
			end
			ST_DONE: begin
				if (!tick_q && free_found) begin
					mem_we    = 1'b1;
					mem_waddr = free_idx;
					mem_wdata = '{etype: cur_type_q, key: cur_key_q, payload: '0,
						remaining: reload};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (state_q == ST_RD) begin
			rd_data_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			tick_q       <= 1'b0;
			cur_type_q   <= '0;
			cur_key_q    <= '0;
			cur_pay_q    <= '0;
			valid_q      <= '0;
			pend_q       <= '0;
			hold_valid_q <= 1'b0;
			hold_q       <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_push) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						tick_q     <= action;
						cur_type_q <= event_type;
						cur_key_q  <= key_tag;
						cur_pay_q  <= payload_tag;
						idx_q      <= '0;
						if (!action && !throttled) begin
							hold_q       <= '{etype: event_type, key: key_tag,
								payload: payload_tag, delayed: 1'b0, full: 1'b0};
							hold_valid_q <= 1'b1;
							state_q      <= ST_FLUSH;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					if (valid_q[idx_q]) begin
						state_q <= ST_EV;
					end else if (last_ent) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + etc_pkg::IDX_W'(1);
					end
				end
				ST_EV: begin
					if (!ev_block) begin
						if (!tick_q && match) begin
							// coalesce: drop the event, keep its payload
							pend_q[idx_q] <= 1'b1;
							state_q       <= ST_IDLE;
						end else begin
							if (tick_q && expired) begin
								if (pend_q[idx_q]) begin
									if (hold_valid_q) begin
										out_q      <= hold_q;
										out_last_q <= 1'b0;
									end
									hold_q <= '{etype: rd_data_q.etype, key: rd_data_q.key,
										payload: rd_data_q.payload, delayed: 1'b1, full: 1'b0};
									hold_valid_q  <= 1'b1;
									pend_q[idx_q] <= 1'b0;
								end else begin
									valid_q[idx_q] <= 1'b0;
								end
							end
							if (last_ent) begin
								state_q <= ST_DONE;
							end else begin
								idx_q   <= idx_q + etc_pkg::IDX_W'(1);
								state_q <= ST_RD;
							end
						end
					end
				end
				ST_DONE: begin
					if (!tick_q) begin
						if (free_found) begin
							valid_q[free_idx] <= 1'b1;
							pend_q[free_idx]  <= 1'b0;
						end
						hold_q       <= '{etype: cur_type_q, key: cur_key_q,
							payload: cur_pay_q, delayed: 1'b0, full: !free_found};
						hold_valid_q <= 1'b1;
						state_q      <= ST_FLUSH;
					end else begin
						state_q <= hold_valid_q ? ST_FLUSH : ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						out_q        <= hold_q;
						out_last_q   <= 1'b1;
						hold_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !hold_valid_q)
		else $error("held result left behind in idle");

	a_pend_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		((pend_q & ~valid_q) == '0))
		else $error("pending payload on a free entry");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != ST_IDLE))
		else $error("accepted transaction not taken up");

	a_open_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !tick_q && free_found) |-> !valid_q[free_idx])
		else $error("entry opened over a valid entry");
`endif

endmodule
